### rtl/differential_drive_mixer_ramp_core_defines.svh
// assertion helpers for the core rtl file
`ifndef DIFFERENTIAL_DRIVE_MIXER_RAMP_CORE_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_MIXER_RAMP_CORE_DEFINES_SVH

// same-cycle implication
`define DDMR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DDMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ddmr_pkg.sv
package ddmr_pkg;

   localparam int ALU_W  = 22;
   localparam int PROD_W = 2 * ALU_W;

   // floor division by 7 and truncating division by 1000 as reciprocal multiplies
   localparam int DIV7_SHIFT    = 15;
   localparam int DIV1000_SHIFT = 29;
   localparam logic signed [ALU_W-1:0] DIV7_RECIP_POS = ALU_W'(4682);
   localparam logic signed [ALU_W-1:0] DIV7_RECIP_NEG = ALU_W'(4681);
   localparam logic signed [ALU_W-1:0] DIV1000_RECIP  = ALU_W'(536871);

   localparam logic signed [4:0] AXIS_OFFSET = 5'sd7;
   localparam logic [10:0]       GAIN_ONE    = 11'd1000;
   localparam logic [7:0]        DUTY_MAX    = 8'd255;

   localparam logic [7:0]  THROTTLE_SPAN_RST = 8'd150;
   localparam logic [7:0]  STEER_SPAN_RST    = 8'd80;
   localparam logic [2:0]  DEADBAND_RST      = 3'd1;
   localparam logic [6:0]  SLEW_STEP_RST     = 7'd6;
   localparam logic [5:0]  TRIM_STEP_RST     = 6'd2;
   localparam logic [9:0]  BALANCE_MIN_RST   = 10'd850;
   localparam logic [10:0] BALANCE_MAX_RST   = 11'd1150;

   typedef struct packed {
      logic signed [3:0] joy_x;
      logic signed [3:0] joy_y;
   } req_type;

   typedef struct packed {
      logic [7:0]  left_duty;
      logic        left_forward;
      logic [7:0]  right_duty;
      logic        right_forward;
      logic [10:0] balance_gain;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  throttle_span;
      logic [7:0]  steer_span;
      logic [2:0]  deadband;
      logic [6:0]  slew_step;
      logic [5:0]  trim_step;
      logic [9:0]  balance_min;
      logic [10:0] balance_max;
   } cfg_type;

   typedef enum logic [2:0] {
      REG_THROTTLE_SPAN = 3'd0,
      REG_STEER_SPAN    = 3'd1,
      REG_DEADBAND      = 3'd2,
      REG_SLEW_STEP     = 3'd3,
      REG_TRIM_STEP     = 3'd4,
      REG_BALANCE_MIN   = 3'd5,
      REG_BALANCE_MAX   = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_MUL_DIV7,
      ALU_MUL_DIV1000
   } alu_op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_Y_MUL,
      S_Y_DIV,
      S_Y_SUB,
      S_X_MUL,
      S_X_DIV,
      S_X_SUB,
      S_MIX_L,
      S_MIX_R,
      S_G_MUL,
      S_ABS,
      S_G_DIV,
      S_SIGN,
      S_G_ADJ,
      S_L_UP,
      S_L_DN,
      S_R_UP,
      S_R_DN,
      S_DONE
   } state_type;

endpackage

### rtl/ddmr_alu.sv
module ddmr_alu (
   input  ddmr_pkg::alu_op_type              op,
   input  logic signed [ddmr_pkg::ALU_W-1:0] a,
   input  logic signed [ddmr_pkg::ALU_W-1:0] b,
   output logic signed [ddmr_pkg::ALU_W-1:0] y
);

   localparam int AW = ddmr_pkg::ALU_W;
   localparam int PW = ddmr_pkg::PROD_W;

   logic signed [PW-1:0] prod;

   assign prod = PW'(a) * PW'(b);

   always_comb begin
      case (op)
         ddmr_pkg::ALU_ADD:         y = a + b;
         ddmr_pkg::ALU_SUB:         y = a - b;
         ddmr_pkg::ALU_MUL:         y = AW'(prod);
         ddmr_pkg::ALU_MUL_DIV7:    y = AW'(prod >>> ddmr_pkg::DIV7_SHIFT);
         ddmr_pkg::ALU_MUL_DIV1000: y = AW'(prod >>> ddmr_pkg::DIV1000_SHIFT);
         default:                   y = '0;
      endcase
   end

endmodule

### rtl/ddmr_csr.sv
module ddmr_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output ddmr_pkg::cfg_type cfg
);

   ddmr_pkg::cfg_type       cfg_ff;
   ddmr_pkg::cfg_type       cfg_in;
   ddmr_pkg::reg_index_type index;
   logic                    wr_en;

   assign index      = ddmr_pkg::reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            ddmr_pkg::REG_THROTTLE_SPAN: cfg_in.throttle_span = csr_pwdata[7:0];
            ddmr_pkg::REG_STEER_SPAN:    cfg_in.steer_span    = csr_pwdata[7:0];
            ddmr_pkg::REG_DEADBAND:      cfg_in.deadband      = csr_pwdata[2:0];
            ddmr_pkg::REG_SLEW_STEP:     cfg_in.slew_step     = csr_pwdata[6:0];
            ddmr_pkg::REG_TRIM_STEP:     cfg_in.trim_step     = csr_pwdata[5:0];
            ddmr_pkg::REG_BALANCE_MIN:   cfg_in.balance_min   = csr_pwdata[9:0];
            ddmr_pkg::REG_BALANCE_MAX:   cfg_in.balance_max   = csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         ddmr_pkg::REG_THROTTLE_SPAN: csr_prdata = 32'(cfg_ff.throttle_span);
         ddmr_pkg::REG_STEER_SPAN:    csr_prdata = 32'(cfg_ff.steer_span);
         ddmr_pkg::REG_DEADBAND:      csr_prdata = 32'(cfg_ff.deadband);
         ddmr_pkg::REG_SLEW_STEP:     csr_prdata = 32'(cfg_ff.slew_step);
         ddmr_pkg::REG_TRIM_STEP:     csr_prdata = 32'(cfg_ff.trim_step);
         ddmr_pkg::REG_BALANCE_MIN:   csr_prdata = 32'(cfg_ff.balance_min);
         ddmr_pkg::REG_BALANCE_MAX:   csr_prdata = 32'(cfg_ff.balance_max);
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.throttle_span <= ddmr_pkg::THROTTLE_SPAN_RST;
         cfg_ff.steer_span    <= ddmr_pkg::STEER_SPAN_RST;
         cfg_ff.deadband      <= ddmr_pkg::DEADBAND_RST;
         cfg_ff.slew_step     <= ddmr_pkg::SLEW_STEP_RST;
         cfg_ff.trim_step     <= ddmr_pkg::TRIM_STEP_RST;
         cfg_ff.balance_min   <= ddmr_pkg::BALANCE_MIN_RST;
         cfg_ff.balance_max   <= ddmr_pkg::BALANCE_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/differential_drive_mixer_ramp_core.sv
// Differential-drive mixer: each joystick transfer (joy_x, joy_y) is dead-zoned, scaled to
// speed and turn, mixed into left and right targets, the left target is scaled by the
// adaptive balance gain, and both motor outputs ramp toward their targets by the slew step.
// A sequencer runs 17 steps through a single shared add/subtract/multiply unit, a done
// state then places the result, and the block accepts again on the cycle after, so a new
// transfer is accepted only once the previous result has been placed. req_stall is high
// while a transfer is being worked on and while a finished result cannot be placed because
// the previous one is still stalled.
// The result register holds one result, so the next transfer is accepted while it waits.
// Registers sit at byte address 4*i (throttle span, steer span, dead zone width, slew step,
// balance trim step, balance_min, balance_max) and should only be written when the block
// is idle.
`include "differential_drive_mixer_ramp_core_defines.svh"

module differential_drive_mixer_ramp_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ddmr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ddmr_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int AW = ddmr_pkg::ALU_W;

   ddmr_pkg::cfg_type    cfg;
   ddmr_pkg::state_type  state_ff, state_in;
   ddmr_pkg::alu_op_type alu_op;
   logic signed [AW-1:0] alu_a, alu_b, alu_y;

   logic signed [4:0]    kx_ff, kx_in, ky_ff, ky_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [9:0]    speed_ff, speed_in, turn_ff, turn_in;
   logic signed [11:0]   lt_ff, lt_in, rt_ff, rt_in;
   logic                 neg_ff, neg_in;
   logic [10:0]          gain_ff, gain_in;
   logic signed [11:0]   lout_ff, lout_in, rout_ff, rout_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ddmr_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic [3:0]           x_abs, y_abs;
   logic signed [4:0]    kx_new, ky_new;
   logic                 gain_upd;
   logic signed [AW-1:0] step_s, bal_step_s, bmin_s, bmax_s;
   logic [11:0]          lmag, rmag;
   logic [7:0]           lduty, rduty;

   logic                 in_fire, out_fire, out_held, done_go;
   logic                 at_first, at_idle, at_done, at_gadj, rev_ok;

   ddmr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ddmr_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   // dead zone and axis offset
   assign x_abs  = req_data.joy_x[3] ? 4'(-req_data.joy_x) : req_data.joy_x;
   assign y_abs  = req_data.joy_y[3] ? 4'(-req_data.joy_y) : req_data.joy_y;
   assign kx_new = (x_abs <= {1'b0, cfg.deadband}) ? ddmr_pkg::AXIS_OFFSET :
                   5'({req_data.joy_x[3], req_data.joy_x}) + ddmr_pkg::AXIS_OFFSET;
   assign ky_new = (y_abs <= {1'b0, cfg.deadband}) ? ddmr_pkg::AXIS_OFFSET :
                   5'({req_data.joy_y[3], req_data.joy_y}) + ddmr_pkg::AXIS_OFFSET;

   assign gain_upd   = (turn_ff == '0) && (speed_ff != '0);
   assign step_s     = AW'(cfg.slew_step);
   assign bal_step_s = AW'(cfg.trim_step);
   assign bmin_s     = AW'(cfg.balance_min);
   assign bmax_s     = AW'(cfg.balance_max);

   // duty magnitude
   assign lmag  = lout_ff[11] ? 12'(-lout_ff) : lout_ff;
   assign rmag  = rout_ff[11] ? 12'(-rout_ff) : rout_ff;
   assign lduty = (lmag > 12'(ddmr_pkg::DUTY_MAX)) ? ddmr_pkg::DUTY_MAX : lmag[7:0];
   assign rduty = (rmag > 12'(ddmr_pkg::DUTY_MAX)) ? ddmr_pkg::DUTY_MAX : rmag[7:0];

   assign req_stall = (state_ff != ddmr_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      kx_in        = kx_ff;
      ky_in        = ky_ff;
      acc_in       = acc_ff;
      speed_in     = speed_ff;
      turn_in      = turn_ff;
      lt_in        = lt_ff;
      rt_in        = rt_ff;
      neg_in       = neg_ff;
      gain_in      = gain_ff;
      lout_in      = lout_ff;
      rout_in      = rout_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      alu_op       = ddmr_pkg::ALU_ADD;
      alu_a        = '0;
      alu_b        = '0;
      case (state_ff)
         ddmr_pkg::S_IDLE: begin
            if (req_valid) begin
               kx_in    = kx_new;
               ky_in    = ky_new;
               state_in = ddmr_pkg::S_Y_MUL;
            end
         end
         // speed = floor(k*max/7) - max
         ddmr_pkg::S_Y_MUL: begin
            alu_op   = ddmr_pkg::ALU_MUL;
            alu_a    = AW'(cfg.throttle_span);
            alu_b    = AW'(ky_ff);
            acc_in   = alu_y;
            state_in = ddmr_pkg::S_Y_DIV;
         end
         ddmr_pkg::S_Y_DIV: begin
            alu_op   = ddmr_pkg::ALU_MUL_DIV7;
            alu_a    = acc_ff;
            alu_b    = ky_ff[4] ? ddmr_pkg::DIV7_RECIP_NEG : ddmr_pkg::DIV7_RECIP_POS;
            acc_in   = alu_y;
            state_in = ddmr_pkg::S_Y_SUB;
         end
         ddmr_pkg::S_Y_SUB: begin
            alu_op   = ddmr_pkg::ALU_SUB;
            alu_a    = acc_ff;
            alu_b    = AW'(cfg.throttle_span);
            speed_in = alu_y[9:0];
            state_in = ddmr_pkg::S_X_MUL;
         end
         ddmr_pkg::S_X_MUL: begin
            alu_op   = ddmr_pkg::ALU_MUL;
            alu_a    = AW'(cfg.steer_span);
            alu_b    = AW'(kx_ff);
            acc_in   = alu_y;
            state_in = ddmr_pkg::S_X_DIV;
         end
         ddmr_pkg::S_X_DIV: begin
            alu_op   = ddmr_pkg::ALU_MUL_DIV7;
            alu_a    = acc_ff;
            alu_b    = kx_ff[4] ? ddmr_pkg::DIV7_RECIP_NEG : ddmr_pkg::DIV7_RECIP_POS;
            acc_in   = alu_y;
            state_in = ddmr_pkg::S_X_SUB;
         end
         ddmr_pkg::S_X_SUB: begin
            alu_op   = ddmr_pkg::ALU_SUB;
            alu_a    = acc_ff;
            alu_b    = AW'(cfg.steer_span);
            turn_in  = alu_y[9:0];
            state_in = ddmr_pkg::S_MIX_L;
         end
         ddmr_pkg::S_MIX_L: begin
            alu_op   = ddmr_pkg::ALU_ADD;
            alu_a    = AW'(speed_ff);
            alu_b    = AW'(turn_ff);
            lt_in    = alu_y[11:0];
            state_in = ddmr_pkg::S_MIX_R;
         end
         ddmr_pkg::S_MIX_R: begin
            alu_op   = ddmr_pkg::ALU_SUB;
            alu_a    = AW'(speed_ff);
            alu_b    = AW'(turn_ff);
            rt_in    = alu_y[11:0];
            state_in = ddmr_pkg::S_G_MUL;
         end
         // left target times gain, truncated toward zero
         ddmr_pkg::S_G_MUL: begin
            alu_op   = ddmr_pkg::ALU_MUL;
            alu_a    = AW'(lt_ff);
            alu_b    = AW'(gain_ff);
            acc_in   = alu_y;
            state_in = ddmr_pkg::S_ABS;
         end
         ddmr_pkg::S_ABS: begin
            alu_op   = ddmr_pkg::ALU_SUB;
            alu_b    = acc_ff;
            neg_in   = acc_ff[AW-1];
            acc_in   = acc_ff[AW-1] ? alu_y : acc_ff;
            state_in = ddmr_pkg::S_G_DIV;
         end
         ddmr_pkg::S_G_DIV: begin
            alu_op   = ddmr_pkg::ALU_MUL_DIV1000;
            alu_a    = acc_ff;
            alu_b    = ddmr_pkg::DIV1000_RECIP;
            acc_in   = alu_y;
            state_in = ddmr_pkg::S_SIGN;
         end
         ddmr_pkg::S_SIGN: begin
            alu_op   = ddmr_pkg::ALU_SUB;
            alu_b    = acc_ff;
            lt_in    = neg_ff ? alu_y[11:0] : acc_ff[11:0];
            state_in = ddmr_pkg::S_G_ADJ;
         end
         // balance adapt on previous outputs when turn is zero and speed is not, then clamp with min taking priority
         ddmr_pkg::S_G_ADJ: begin
            alu_op = (lout_ff > rout_ff) ? ddmr_pkg::ALU_SUB : ddmr_pkg::ALU_ADD;
            alu_a  = AW'(gain_ff);
            alu_b  = (lout_ff == rout_ff) ? '0 : bal_step_s;
            if (gain_upd) begin
               if (alu_y < bmin_s) begin
                  gain_in = {1'b0, cfg.balance_min};
               end else if (alu_y > bmax_s) begin
                  gain_in = cfg.balance_max;
               end else begin
                  gain_in = alu_y[10:0];
               end
            end
            state_in = ddmr_pkg::S_L_UP;
         end
         ddmr_pkg::S_L_UP: begin
            alu_op = ddmr_pkg::ALU_ADD;
            alu_a  = AW'(lout_ff);
            alu_b  = step_s;
            if (lout_ff < lt_ff) begin
               lout_in = alu_y[11:0];
            end
            state_in = ddmr_pkg::S_L_DN;
         end
         ddmr_pkg::S_L_DN: begin
            alu_op = ddmr_pkg::ALU_SUB;
            alu_a  = AW'(lout_ff);
            alu_b  = step_s;
            if (lout_ff > lt_ff) begin
               lout_in = alu_y[11:0];
            end
            state_in = ddmr_pkg::S_R_UP;
         end
         ddmr_pkg::S_R_UP: begin
            alu_op = ddmr_pkg::ALU_ADD;
            alu_a  = AW'(rout_ff);
            alu_b  = step_s;
            if (rout_ff < rt_ff) begin
               rout_in = alu_y[11:0];
            end
            state_in = ddmr_pkg::S_R_DN;
         end
         ddmr_pkg::S_R_DN: begin
            alu_op = ddmr_pkg::ALU_SUB;
            alu_a  = AW'(rout_ff);
            alu_b  = step_s;
            if (rout_ff > rt_ff) begin
               rout_in = alu_y[11:0];
            end
            state_in = ddmr_pkg::S_DONE;
         end
         ddmr_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.left_duty      = lduty;
               rsp_data_in.left_forward   = ~lout_ff[11];
               rsp_data_in.right_duty     = rduty;
               rsp_data_in.right_forward  = ~rout_ff[11];
               rsp_data_in.balance_gain   = gain_ff;
               state_in                   = ddmr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ddmr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ddmr_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= ddmr_pkg::GAIN_ONE;
         lout_ff      <= '0;
         rout_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_ff      <= gain_in;
         lout_ff      <= lout_in;
         rout_ff      <= rout_in;
      end
   end

   always_ff @(posedge clock) begin
      kx_ff       <= kx_in;
      ky_ff       <= ky_in;
      acc_ff      <= acc_in;
      speed_ff    <= speed_in;
      turn_ff     <= turn_in;
      lt_ff       <= lt_in;
      rt_ff       <= rt_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign in_fire  = req_valid && !req_stall;
   assign out_fire = rsp_valid && !rsp_stall;
   assign out_held = rsp_valid && rsp_stall;
   assign at_first = (state_ff == ddmr_pkg::S_Y_MUL);
   assign at_idle  = (state_ff == ddmr_pkg::S_IDLE);
   assign at_done  = (state_ff == ddmr_pkg::S_DONE);
   assign at_gadj  = (state_ff == ddmr_pkg::S_G_ADJ);
   assign done_go  = at_done && !out_held;
   assign rev_ok   = (rsp_data.left_forward || rsp_data.left_duty != 8'd0) &&
                     (rsp_data.right_forward || rsp_data.right_duty != 8'd0);

   `DDMR_ASSERT_NEXT(a_accept_starts, clock, reset, in_fire, at_first, "sequence not started")
   `DDMR_ASSERT_NEXT(a_done_delivers, clock, reset, done_go, rsp_valid && at_idle, "result lost")
   `DDMR_ASSERT_NEXT(a_taken_clears, clock, reset, out_fire && !at_done, !rsp_valid, "repeat")
   `DDMR_ASSERT_NEXT(a_gain_hold, clock, reset, !at_gadj, $stable(gain_ff), "gain moved")
   `DDMR_ASSERT_NOW(a_reverse_nonzero, clock, reset, rsp_valid, rev_ok, "reverse with zero duty")

endmodule
